### sv/smq_pkg.sv
// Shared types and codes of the shared-buffer multi-queue unit.
package smq_pkg;

  localparam int MODE_W   = 2;
  localparam int QID_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADQ  = 2'd3;

  localparam logic [CFG_W-1:0] ACTIVE_QUEUES_RESET = 5'd16;

  // microcode step addresses
  typedef enum logic [3:0] {
    UC_CLR,
    UC_FETCH,
    UC_DECODE,
    UC_PUSH,
    UC_PUSH2,
    UC_POP,
    UC_POP2,
    UC_PEEK,
    UC_EMIT
  } uc_step_t;

  // how the sequencer picks the next step
  typedef enum logic [2:0] {
    JMP_GOTO,
    JMP_WAIT_IN,
    JMP_WAIT_CLR,
    JMP_DISPATCH,
    JMP_WAIT_OUT
  } uc_jmp_t;

  // operation class found at decode
  typedef enum logic [1:0] {
    CLS_DONE,
    CLS_PUSH,
    CLS_POP,
    CLS_PEEK
  } uc_cls_t;

  typedef struct packed {
    logic     accept;
    logic     q_clear;
    logic     decode;
    logic     push_a;
    logic     push_b;
    logic     pop_a;
    logic     pop_b;
    logic     peek_rd;
    logic     emit;
    uc_jmp_t  jmp;
    uc_step_t target;
  } uc_ctl_t;

  typedef struct packed {
    logic    clr_done;
    logic    out_free;
    uc_cls_t cls;
  } smq_flags_t;

endpackage

### sv/smq_if.sv
// Channel interfaces of the shared-buffer multi-queue unit.
interface smq_in_if;
  import smq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [QID_W-1:0]          queue_id;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, mode, queue_id, value, input ready);
  modport sink (input valid, mode, queue_id, value, output ready);
endinterface

interface smq_out_if;
  import smq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      front_valid;
  logic signed [VALUE_W-1:0] front_value;
  modport source (output valid, status, front_valid, front_value, input ready);
  modport sink (input valid, status, front_valid, front_value, output ready);
endinterface

interface smq_cfg_if;
  import smq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### sv/smq_ram.sv
// Generic simple dual-port RAM with registered, read-first read port.
module smq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/smq_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
module smq_sequencer import smq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  smq_flags_t flags,
  output uc_ctl_t    ctl
);

  uc_step_t step_r, step_nxt;

  function automatic uc_ctl_t uc_rom(uc_step_t s);
    uc_ctl_t w;
    w = '0;
    w.jmp = JMP_GOTO;
    w.target = UC_FETCH;
    case (s)
      UC_CLR: begin
        w.q_clear = 1'b1;
        w.jmp = JMP_WAIT_CLR;
        w.target = UC_FETCH;
      end
      UC_FETCH: begin
        w.accept = 1'b1;
        w.jmp = JMP_WAIT_IN;
        w.target = UC_DECODE;
      end
      UC_DECODE: begin
        w.decode = 1'b1;
        w.jmp = JMP_DISPATCH;
      end
      UC_PUSH: begin
        w.push_a = 1'b1;
        w.target = UC_PUSH2;
      end
      UC_PUSH2: begin
        w.push_b = 1'b1;
        w.target = UC_EMIT;
      end
      UC_POP: begin
        w.pop_a = 1'b1;
        w.target = UC_POP2;
      end
      UC_POP2: begin
        w.pop_b = 1'b1;
        w.target = UC_EMIT;
      end
      UC_PEEK: begin
        w.peek_rd = 1'b1;
        w.target = UC_EMIT;
      end
      UC_EMIT: begin
        w.emit = 1'b1;
        w.jmp = JMP_WAIT_OUT;
        w.target = UC_FETCH;
      end
      default: begin
        w.jmp = JMP_GOTO;
        w.target = UC_FETCH;
      end
    endcase
    return w;
  endfunction

  // control word of the current step
  always_comb begin
    ctl = uc_rom(step_r);
  end

  // next step
  always_comb begin
    step_nxt = step_r;
    case (ctl.jmp)
      JMP_GOTO:     step_nxt = ctl.target;
      JMP_WAIT_IN:  if (in_valid) step_nxt = ctl.target;
      JMP_WAIT_CLR: if (flags.clr_done) step_nxt = ctl.target;
      JMP_WAIT_OUT: if (flags.out_free) step_nxt = ctl.target;
      JMP_DISPATCH: begin
        case (flags.cls)
          CLS_PUSH: step_nxt = UC_PUSH;
          CLS_POP:  step_nxt = UC_POP;
          CLS_PEEK: step_nxt = UC_PEEK;
          default:  step_nxt = UC_EMIT;
        endcase
      end
      default:      step_nxt = UC_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= UC_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### sv/smq_datapath.sv
// Datapath: queue table, link and data stores, free list and result register.
module smq_datapath import smq_pkg::*; #(
  parameter int SLOTS      = 128,
  parameter int QUEUES     = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  uc_ctl_t                   ctl,
  output smq_flags_t                flags,
  input  logic                      in_fire,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic [QID_W-1:0]          in_queue_id,
  input  logic signed [VALUE_W-1:0] in_value,
  smq_cfg_if.sink                   cfg_chan,
  smq_out_if.source                 out_chan
);

  localparam int PW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QSW = 2 * PW + 1;

  // latched item
  logic [MODE_W-1:0]         mode_r;
  logic [QID_W-1:0]          qid_r;
  logic signed [VALUE_W-1:0] value_r;

  logic [CFG_W-1:0] active_r;
  logic [QW-1:0]    clr_r;
  logic [PW-1:0]    fh_r;
  logic [CW-1:0]    fresh_r;
  logic [CW-1:0]    count_r;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                fv_r;
  uc_cls_t             cls;

  // queue table: {nonempty, head, tail}
  logic           q_we;
  logic [QW-1:0]  q_waddr;
  logic [QSW-1:0] q_wdata;
  logic [QSW-1:0] q_rdata;
  logic           q_ne;
  logic [PW-1:0]  q_head, q_tail;

  logic          l_we, l_re;
  logic [PW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;
  logic          link_fresh_r;
  logic [PW-1:0] link_addr_r;
  logic [PW-1:0] link_val;

  logic [DATA_WIDTH-1:0]        d_rdata;
  logic signed [DATA_WIDTH-1:0] d_rdata_s;

  logic out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic out_fv_r;
  logic signed [VALUE_W-1:0] out_value_r;

  logic bad_q, free_avail, out_free, load_out;

  assign q_ne   = q_rdata[2*PW];
  assign q_head = q_rdata[2*PW-1:PW];
  assign q_tail = q_rdata[PW-1:0];

  assign free_avail = (count_r != '0);
  assign bad_q = ({1'b0, qid_r} >= active_r) || (32'(qid_r) >= 32'(QUEUES));

  // classify the item and pick its status
  always_comb begin
    status_nxt = ST_OK;
    cls = CLS_DONE;
    if (mode_r == MODE_NOP) begin
      cls = CLS_DONE;
    end else if (bad_q) begin
      status_nxt = ST_BADQ;
    end else if (mode_r == MODE_PUSH) begin
      if (!free_avail) begin
        status_nxt = ST_FULL;
      end else begin
        cls = CLS_PUSH;
      end
    end else if (!q_ne) begin
      status_nxt = ST_EMPTY;
    end else if (mode_r == MODE_POP) begin
      cls = CLS_POP;
    end else begin
      cls = CLS_PEEK;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign load_out = ctl.emit && out_free;

  assign flags.clr_done = (clr_r == QW'(QUEUES - 1));
  assign flags.out_free = out_free;
  assign flags.cls      = cls;

  // untouched slots still hold their reset link to the next slot
  assign link_val = !link_fresh_r ? l_rdata :
                    (link_addr_r == PW'(SLOTS - 1)) ? '0 : link_addr_r + PW'(1);

  // queue table write port
  always_comb begin
    q_we    = ctl.q_clear || ctl.push_b || ctl.pop_b;
    q_waddr = QW'(qid_r);
    q_wdata = '0;
    if (ctl.q_clear) begin
      q_waddr = clr_r;
    end else if (ctl.push_b) begin
      q_wdata = {1'b1, (q_ne ? q_head : fh_r), fh_r};
    end else if (ctl.pop_b) begin
      q_wdata = {(q_head != q_tail), link_val, q_tail};
    end
  end

  // link store ports
  always_comb begin
    l_re    = ctl.push_a || ctl.pop_a;
    l_raddr = ctl.pop_a ? q_head : fh_r;
    l_we    = (ctl.push_a && q_ne) || ctl.pop_a || ctl.push_b;
    l_waddr = fh_r;
    l_wdata = '0;
    if (ctl.push_a) begin
      l_waddr = q_tail;
      l_wdata = fh_r;
    end else if (ctl.pop_a) begin
      l_waddr = q_head;
      l_wdata = fh_r;
    end
  end

  smq_ram #(.WIDTH(QSW), .DEPTH(QUEUES)) u_qtab (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (in_fire),
    .raddr (QW'(in_queue_id)),
    .rdata (q_rdata)
  );

  smq_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_link (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  smq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_data (
    .clk   (clk),
    .we    (ctl.push_a),
    .waddr (fh_r),
    .wdata (DATA_WIDTH'(value_r)),
    .re    (ctl.peek_rd),
    .raddr (q_head),
    .rdata (d_rdata)
  );

  assign d_rdata_s = d_rdata;
  assign cfg_chan.ready = 1'b1;

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= in_mode;
      qid_r   <= in_queue_id;
      value_r <= in_value;
    end
    if (ctl.decode) begin
      status_r <= status_nxt;
      fv_r     <= (cls == CLS_PEEK);
    end
    if (l_re) begin
      link_fresh_r <= (CW'(l_raddr) >= fresh_r);
      link_addr_r  <= l_raddr;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_fv_r     <= fv_r;
      out_value_r  <= fv_r ? VALUE_W'(d_rdata_s) : '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_QUEUES_RESET;
      clr_r       <= '0;
      fh_r        <= '0;
      fresh_r     <= '0;
      count_r     <= CW'(SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        active_r <= cfg_chan.data;
      end
      if (ctl.q_clear && !flags.clr_done) begin
        clr_r <= clr_r + QW'(1);
      end
      if (ctl.push_b) begin
        fh_r    <= link_val;
        count_r <= count_r - CW'(1);
        if (link_fresh_r) begin
          fresh_r <= fresh_r + CW'(1);
        end
      end else if (ctl.pop_a) begin
        fh_r <= q_head;
        if (count_r < CW'(SLOTS)) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.front_valid = out_fv_r;
  assign out_chan.front_value = out_value_r;

endmodule

### sv/shared_buffer_multi_queue_unit.sv
// Top level of the shared-buffer multi-queue unit.
//
// Up to QUEUES FIFO queues live as linked lists in one store of SLOTS data
// slots; free slots form a free list. Each input item pushes a value,
// pops or peeks at the front of one queue or does nothing, and yields
// exactly one result item with a status (ok, empty, full, bad queue id)
// and, on a good peek, the front word. A microcoded sequencer runs one
// item at a time: a bad id, a no-op or an error runs only the fetch,
// decode and emit steps; a peek adds the peek step, a push adds push and
// push2, a pop pop and pop2, as the queue table read and then the link
// or data store read are registered. The result waits in an output
// register; the next item is taken while it waits, and only a later
// result stalls on it. After reset every queue table entry is cleared
// before the first item; configuration writes are taken at any time. The
// active_queues register (reset 16) rejects queue ids at or above it.
module shared_buffer_multi_queue_unit import smq_pkg::*; #(
  parameter int SLOTS      = 128,
  parameter int QUEUES     = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  smq_in_if.sink    in_chan,
  smq_out_if.source out_chan,
  smq_cfg_if.sink   cfg_chan
);

  uc_ctl_t    ctl;
  smq_flags_t flags;
  logic       in_fire;

  // take an item only in the fetch step
  assign in_chan.ready = ctl.accept;
  assign in_fire       = in_chan.valid && ctl.accept;

  smq_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .flags    (flags),
    .ctl      (ctl)
  );

  smq_datapath #(
    .SLOTS      (SLOTS),
    .QUEUES     (QUEUES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .flags       (flags),
    .in_fire     (in_fire),
    .in_mode     (in_chan.mode),
    .in_queue_id (in_chan.queue_id),
    .in_value    (in_chan.value),
    .cfg_chan    (cfg_chan),
    .out_chan    (out_chan)
  );

endmodule

### tb/tb_shared_buffer_multi_queue_unit.sv
// Self-checking testbench for the shared-buffer multi-queue unit.
`timescale 1ns / 100ps

module tb_shared_buffer_multi_queue_unit;
  import smq_pkg::*;

  localparam int SLOTS  = 128;
  localparam int QUEUES = 16;
  localparam int SLOT_W = 7;

  // One result item as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic                      front_valid;
    logic signed [VALUE_W-1:0] front_value;
  } smq_result_t;

  // Mirrors the linked-list store and the free list, predicts one result per
  // accepted request and checks results in order against those predictions.
  class queue_scoreboard;
    logic signed [VALUE_W-1:0] word_mem [SLOTS];
    logic [SLOT_W-1:0]         next_slot [SLOTS];
    logic [SLOT_W-1:0]         q_head [QUEUES];
    logic [SLOT_W-1:0]         q_tail [QUEUES];
    bit                        q_busy [QUEUES];
    logic [SLOT_W-1:0]         free_top;
    int                        free_slots;
    int                        active_q;
    smq_result_t               pending_results [$];
    int                        errors;
    int                        reported;
    int                        mode_seen [4];
    int                        status_seen [4];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        word_mem[i]  = '0;
        next_slot[i] = SLOT_W'((i + 1) % SLOTS);
      end
      for (int q = 0; q < QUEUES; q++) begin
        q_head[q] = '0;
        q_tail[q] = '0;
        q_busy[q] = 1'b0;
      end
      for (int k = 0; k < 4; k++) begin
        mode_seen[k]   = 0;
        status_seen[k] = 0;
      end
      free_top   = '0;
      free_slots = SLOTS;
      active_q   = int'(ACTIVE_QUEUES_RESET);
      errors     = 0;
      reported   = 0;
    endfunction

    function smq_result_t serve_request(logic [MODE_W-1:0] mode, logic [QID_W-1:0] qid,
                                        logic signed [VALUE_W-1:0] value);
      smq_result_t       r;
      logic [SLOT_W-1:0] slot;
      r.status      = ST_OK;
      r.front_valid = 1'b0;
      r.front_value = '0;
      if (mode == MODE_NOP) begin
        return r;
      end
      if (int'(qid) >= active_q || int'(qid) >= QUEUES) begin
        r.status = ST_BADQ;
      end else if (mode == MODE_PUSH) begin
        if (free_slots == 0) begin
          r.status = ST_FULL;
        end else begin
          slot       = free_top;
          free_top   = next_slot[slot];
          free_slots = free_slots - 1;
          if (q_busy[qid]) next_slot[q_tail[qid]] = slot;
          else q_head[qid] = slot;
          q_tail[qid]     = slot;
          next_slot[slot] = '0;
          q_busy[qid]     = 1'b1;
          word_mem[slot]  = value;
        end
      end else if (!q_busy[qid]) begin
        r.status = ST_EMPTY;
      end else if (mode == MODE_POP) begin
        slot = q_head[qid];
        if (slot == q_tail[qid]) q_busy[qid] = 1'b0;
        else q_head[qid] = next_slot[slot];
        next_slot[slot] = free_top;
        free_top        = slot;
        if (free_slots < SLOTS) free_slots = free_slots + 1;
      end else begin
        r.front_valid = 1'b1;
        r.front_value = word_mem[q_head[qid]];
      end
      return r;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [QID_W-1:0] qid,
                               logic signed [VALUE_W-1:0] value);
      smq_result_t r;
      r = serve_request(mode, qid, value);
      pending_results.push_back(r);
      mode_seen[mode]++;
      status_seen[r.status]++;
    endfunction

    function void check_result(smq_result_t got);
      smq_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("%0t: result with nothing pending: status %0d front_valid %0b front_value %h",
                   $time, got.status, got.front_valid, got.front_value);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.front_valid !== want.front_valid ||
          got.front_value !== want.front_value) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("%0t: mismatch: status %0d (exp %0d) front_valid %0b (exp %0b) front_value %h (exp %h)",
                   $time, got.status, want.status, got.front_valid, want.front_valid,
                   got.front_value, want.front_value);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;  // set to suppress all idling on both sides

  smq_in_if  in_if ();
  smq_out_if out_if ();
  smq_cfg_if cfg_if ();

  queue_scoreboard sb = new();

  shared_buffer_multi_queue_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at random, about 36 percent of the time, unless steady.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = steady || ($urandom_range(0, 99) >= 36);
    end
  end

  // Watch all three handshakes at the rising edge; note requests before
  // checking results so the order within an edge never matters.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.active_q = int'(cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_request(in_if.mode, in_if.queue_id, in_if.value);
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{out_if.status, out_if.front_valid, out_if.front_value});
      end
    end
  end

  // Present one request item; idle first at random, then hold until taken.
  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [QID_W-1:0] qid,
                              input logic signed [VALUE_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid    = 1'b1;
    in_if.mode     = mode;
    in_if.queue_id = qid;
    in_if.value    = value;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Drop the request valid and wait until every predicted result has come.
  task automatic wait_quiet();
    in_if.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write active_queues; only called while the block is idle.
  task automatic write_active(input logic [CFG_W-1:0] count);
    cfg_if.valid = 1'b1;
    cfg_if.data  = count;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Random data word, leaning on the extremes now and then.
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Send n random items with the given push/pop/peek percentages; the rest
  // are no-ops. Most ids fall among the active queues.
  task automatic send_mix(input int n, input int push_pct, input int pop_pct,
                          input int peek_pct);
    int                lim;
    int                r;
    logic [MODE_W-1:0] mode;
    logic [QID_W-1:0]  qid;
    for (int i = 0; i < n; i++) begin
      lim = (sb.active_q > QUEUES) ? QUEUES : sb.active_q;
      r   = $urandom_range(0, 99);
      if (r < push_pct) mode = MODE_PUSH;
      else if (r < push_pct + pop_pct) mode = MODE_POP;
      else if (r < push_pct + pop_pct + peek_pct) mode = MODE_PEEK;
      else mode = MODE_NOP;
      if (lim > 0 && $urandom_range(0, 9) < 8) qid = QID_W'($urandom_range(0, lim - 1));
      else qid = QID_W'($urandom_range(0, QUEUES - 1));
      send_request(mode, qid, pick_word());
    end
  endtask

  initial begin
    // Drive every input to a known value before reset.
    rst_n          = 1'b0;
    steady         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_NOP;
    in_if.queue_id = '0;
    in_if.value    = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items at the reset setting: highest queue, extreme words,
    // FIFO order, pop and peek on an empty queue, no-op.
    send_request(MODE_PUSH, 4'd15, 32'sh7FFF_FFFF);
    send_request(MODE_PUSH, 4'd0, 32'sh8000_0000);
    send_request(MODE_PUSH, 4'd0, '0);
    send_request(MODE_PUSH, 4'd0, -32'sd1);
    send_request(MODE_PEEK, 4'd0, '0);
    send_request(MODE_POP, 4'd0, '0);
    send_request(MODE_PEEK, 4'd0, '0);
    send_request(MODE_POP, 4'd0, '0);
    send_request(MODE_PEEK, 4'd0, '0);
    send_request(MODE_POP, 4'd0, '0);
    send_request(MODE_POP, 4'd0, '0);
    send_request(MODE_PEEK, 4'd0, '0);
    send_request(MODE_NOP, 4'd9, 32'sh5A5A_A5A5);
    send_request(MODE_PEEK, 4'd15, '0);
    wait_quiet();

    // Narrow the active set: queue 15 keeps its word but cannot be reached.
    write_active(5'd4);
    send_request(MODE_PUSH, 4'd4, 32'sd7);
    send_request(MODE_POP, 4'd15, '0);
    send_request(MODE_PEEK, 4'd3, '0);
    send_request(MODE_PUSH, 4'd3, 32'sd123);
    wait_quiet();

    // No active queues: every id is rejected, no-op still passes.
    write_active(5'd0);
    send_request(MODE_PUSH, 4'd0, 32'sd1);
    send_request(MODE_PEEK, 4'd0, '0);
    send_request(MODE_NOP, 4'd0, '0);
    wait_quiet();

    // Above QUEUES behaves as QUEUES; queue 15 reappears intact.
    write_active(5'd31);
    send_request(MODE_PEEK, 4'd15, '0);
    send_request(MODE_POP, 4'd15, '0);
    send_request(MODE_PEEK, 4'd15, '0);
    wait_quiet();

    // Random part at full width, push-heavy.
    write_active(5'd16);
    send_mix(60, 55, 15, 25);

    // Long stretch without idling: fill the store past full, then work
    // around the full boundary.
    steady = 1'b1;
    send_mix(130, 100, 0, 0);
    steady = 1'b0;
    send_mix(40, 40, 30, 25);
    wait_quiet();

    write_active(5'd1);
    send_mix(40, 35, 30, 30);
    wait_quiet();

    // Drain mostly, with every queue reachable.
    write_active(5'd31);
    send_mix(60, 15, 60, 20);
    wait_quiet();

    write_active(5'd5);
    send_mix(40, 35, 30, 30);
    wait_quiet();

    write_active(CFG_W'($urandom_range(0, 31)));
    send_mix(40, 35, 30, 30);
    wait_quiet();

    write_active(5'd16);
    send_mix(60, 10, 70, 15);
    wait_quiet();
    repeat (10) @(posedge clk);

    $display("Requests: %0d push, %0d pop, %0d peek, %0d no-op",
             sb.mode_seen[MODE_PUSH], sb.mode_seen[MODE_POP], sb.mode_seen[MODE_PEEK],
             sb.mode_seen[MODE_NOP]);
    $display("Outcomes: %0d ok, %0d empty, %0d full, %0d bad id; %0d errors",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
             sb.status_seen[ST_BADQ], sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
